>>> rtl/brst_pkg.sv
// Package for the best route selection table: route record, item token,
// opcode and status codes, and the route preference function. No dependencies.
`timescale 1ns / 1ps

package brst_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 256;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_OFFER = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_REPLACED   = 3'd1,
    ST_KEPT       = 3'd2,
    ST_FULL       = 3'd3,
    ST_CLEARED    = 3'd4,
    ST_READ_VALID = 3'd5,
    ST_READ_EMPTY = 3'd6
  } status_t;

  typedef struct packed {
    logic [15:0] family;
    logic [63:0] prefix;
    logic [31:0] pref;
    logic [7:0]  rtype;
    logic [7:0]  path;
    logic [31:0] metric;
    logic [31:0] domain;
    logic [31:0] server;
    logic [31:0] age;
  } route_t;

  // item walking down the cell row
  typedef struct packed {
    logic    vld;
    op_t     op;
    route_t  route;
    logic [7:0] rd_idx;
    logic    done;
    logic    ins;
    status_t status;
    logic [7:0] slot;
    route_t  res;
  } tok_t;

  // true when offered route n beats stored route o
  function automatic logic offered_wins(route_t n, route_t o, logic [31:0] ld);
    logic ext_n;
    logic ext_o;
    ext_n = (n.domain != ld);
    ext_o = (o.domain != ld);
    if (n.pref != o.pref)     return n.pref > o.pref;
    if (n.rtype != o.rtype)   return n.rtype > o.rtype;
    if (n.path != o.path)     return n.path < o.path;
    if (n.metric != o.metric) return n.metric > o.metric;
    if (ext_n != ext_o)       return ext_n;
    if (n.age != o.age)       return n.age < o.age;
    if (n.server != o.server) return n.server > o.server;
    return 1'b0;
  endfunction

endpackage

>>> rtl/brst_cell.sv
// One table slot: holds a stored route and serves the item passing through.
// Depends on brst_pkg.
`timescale 1ns / 1ps

module brst_cell #(
  parameter int unsigned TABLE_DEPTH = brst_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned IDX         = 0,
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] total,
  input  logic [31:0]      local_domain,
  input  brst_pkg::tok_t   tok_in,
  output brst_pkg::tok_t   tok_out
);

  brst_pkg::route_t ent_r;
  brst_pkg::route_t ent_nxt;
  brst_pkg::tok_t   tok_r;
  brst_pkg::tok_t   tok_nxt;

  logic live;
  logic at_end;
  logic key_hit;
  logic rd_hit;

  assign live    = CNT_W'(IDX) < total;
  assign at_end  = CNT_W'(IDX) == total;
  assign key_hit = (ent_r.family == tok_in.route.family) &&
                   (ent_r.prefix == tok_in.route.prefix);
  assign rd_hit  = (IDX < 256) && (tok_in.rd_idx == 8'(IDX));

  always_comb begin
    tok_nxt = tok_in;
    ent_nxt = ent_r;
    if (tok_in.vld && !tok_in.done) begin
      case (tok_in.op)
        brst_pkg::OP_OFFER: begin
          if (live && key_hit) begin
            tok_nxt.done = 1'b1;
            tok_nxt.slot = 8'(IDX);
            if (brst_pkg::offered_wins(tok_in.route, ent_r, local_domain)) begin
              ent_nxt        = tok_in.route;
              tok_nxt.status = brst_pkg::ST_REPLACED;
              tok_nxt.res    = tok_in.route;
            end else begin
              tok_nxt.status = brst_pkg::ST_KEPT;
              tok_nxt.res    = ent_r;
            end
          end else if (at_end) begin
            // first free slot: append
            ent_nxt        = tok_in.route;
            tok_nxt.done   = 1'b1;
            tok_nxt.ins    = 1'b1;
            tok_nxt.slot   = 8'(IDX);
            tok_nxt.status = brst_pkg::ST_INSERTED;
            tok_nxt.res    = tok_in.route;
          end
        end
        brst_pkg::OP_READ: begin
          if (live && rd_hit) begin
            tok_nxt.done   = 1'b1;
            tok_nxt.status = brst_pkg::ST_READ_VALID;
            tok_nxt.res    = ent_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      tok_r     <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/best_route_selection_table_core.sv
// Top level of the best route selection table: cell row, control and output register.
// Depends on brst_pkg and brst_cell.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_* (valid/stall): one item carries an opcode and a route
//   or a read index. Result channel out_* (valid/stall): one result per item.
//   cfg_valid/cfg_ready write local_domain; write it only while idle.
//   Each slot is a cell in a row. An offer or read item enters cell 0 and
//   moves one cell per cycle; the first cell holding the key, or the first
//   free cell, settles an offer, and the cell at the read index settles a
//   read. A settled item is registered at the end of the row and then
//   moved to the output register; clear and the unused opcode skip the row.
//   One item is in flight at a time: a new item waits until the last
//   result has moved on. in_stall is high while an item is in flight; a
//   finished result moves to the output register as soon as it is free, so
//   the next item is accepted while out_stall holds an earlier result.
//   Reset empties the table (count 0) and clears local_domain; no sweep.

module best_route_selection_table_core #(
  parameter int unsigned TABLE_DEPTH = brst_pkg::DEF_TABLE_DEPTH,
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_local_domain,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_address_family,
  input  logic [63:0] in_prefix_key,
  input  logic [31:0] in_local_pref,
  input  logic [7:0]  in_route_type,
  input  logic [7:0]  in_path_length,
  input  logic [31:0] in_metric,
  input  logic [31:0] in_learn_domain,
  input  logic [31:0] in_learn_server_id,
  input  logic [31:0] in_age_stamp,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_slot_index,
  output logic [8:0]  out_entry_count,
  output logic [15:0] out_family,
  output logic [63:0] out_prefix,
  output logic [31:0] out_pref,
  output logic [7:0]  out_type,
  output logic [7:0]  out_path_length,
  output logic [31:0] out_metric,
  output logic [31:0] out_domain,
  output logic [31:0] out_server_id,
  output logic [31:0] out_age
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t           state_r;
  logic [31:0]      ldom_r;
  logic [CNT_W-1:0] total_r;
  brst_pkg::tok_t   tok [TABLE_DEPTH+1];
  brst_pkg::tok_t   inj;

  brst_pkg::status_t res_status_r;
  logic [7:0]        res_slot_r;
  logic [CNT_W-1:0]  res_count_r;
  brst_pkg::route_t  res_route_r;

  brst_pkg::status_t out_status_r;
  logic [7:0]        out_slot_r;
  logic [8:0]        out_count_r;
  brst_pkg::route_t  out_route_r;
  logic              out_valid_r;

  logic              accept;
  brst_pkg::op_t     op_in;
  brst_pkg::route_t  route_in;
  brst_pkg::tok_t    last;
  logic [CNT_W+8:0]  count_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign op_in     = brst_pkg::op_t'(in_opcode);

  assign route_in = '{family: in_address_family, prefix: in_prefix_key,
                      pref: in_local_pref, rtype: in_route_type,
                      path: in_path_length, metric: in_metric,
                      domain: in_learn_domain, server: in_learn_server_id,
                      age: in_age_stamp};

  always_comb begin
    inj        = '0;
    inj.vld    = accept && (op_in == brst_pkg::OP_OFFER || op_in == brst_pkg::OP_READ);
    inj.op     = op_in;
    inj.route  = route_in;
    inj.rd_idx = in_read_index;
    inj.status = (op_in == brst_pkg::OP_READ) ? brst_pkg::ST_READ_EMPTY
                                               : brst_pkg::ST_FULL;
    inj.slot   = (op_in == brst_pkg::OP_READ) ? in_read_index : 8'd0;
  end

  assign tok[0] = inj;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    brst_cell #(.TABLE_DEPTH(TABLE_DEPTH), .IDX(g)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .total        (total_r),
      .local_domain (ldom_r),
      .tok_in       (tok[g]),
      .tok_out      (tok[g+1])
    );
  end

  assign last = tok[TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ldom_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ldom_r <= cfg_local_domain;
      end
      // in S_DONE the hand-over below owns out_valid_r
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_slot_r  <= 8'd0;
            res_route_r <= '0;
            case (op_in)
              brst_pkg::OP_CLEAR: begin
                total_r      <= '0;
                res_status_r <= brst_pkg::ST_CLEARED;
                res_count_r  <= '0;
                state_r      <= S_DONE;
              end
              brst_pkg::OP_NONE: begin
                res_status_r <= brst_pkg::ST_READ_EMPTY;
                res_count_r  <= total_r;
                state_r      <= S_DONE;
              end
              default: begin
                state_r <= S_RUN;
              end
            endcase
          end
        end
        S_RUN: begin
          if (last.vld) begin
            res_status_r <= last.status;
            res_slot_r   <= last.slot;
            res_route_r  <= last.done ? last.res : '0;
            res_count_r  <= total_r + CNT_W'(last.ins);
            total_r      <= total_r + CNT_W'(last.ins);
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_count_r  <= count_ext[8:0];
            out_route_r  <= res_route_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign count_ext = (CNT_W+9)'(res_count_r);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot_index  = out_slot_r;
  assign out_entry_count = out_count_r;
  assign out_family      = out_route_r.family;
  assign out_prefix      = out_route_r.prefix;
  assign out_pref        = out_route_r.pref;
  assign out_type        = out_route_r.rtype;
  assign out_path_length = out_route_r.path;
  assign out_metric      = out_route_r.metric;
  assign out_domain      = out_route_r.domain;
  assign out_server_id   = out_route_r.server;
  assign out_age         = out_route_r.age;

endmodule

>>> sim/tb.sv
// Testbench for best_route_selection_table_core: drives clear, offer, read and
// unused-opcode items, predicts each result with a scoreboard class and
// checks every result field. Depends on brst_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import brst_pkg::*;

  localparam int DEPTH = 256;

  typedef struct {
    op_t         op;
    route_t      rt;
    logic [7:0]  rd_idx;
  } item_t;

  typedef struct {
    status_t     status;
    logic [7:0]  slot;
    logic [8:0]  count;
    route_t      rt;
  } result_t;

  int errors = 0;

  task automatic report(string what, logic [63:0] got, logic [63:0] exp_v);
    $display("mismatch %s: got %0h expected %0h", what, got, exp_v);
    errors++;
  endtask

  class route_table_sb;
    logic [31:0] local_dom;
    int unsigned total;
    route_t slots[DEPTH];
    result_t pending[$];

    function void set_domain(logic [31:0] d);
      local_dom = d;
    endfunction

    function bit beats(route_t n, route_t o);
      bit xn;
      bit xo;
      xn = n.domain != local_dom;
      xo = o.domain != local_dom;
      if (n.pref != o.pref) return n.pref > o.pref;
      if (n.rtype != o.rtype) return n.rtype > o.rtype;
      if (n.path != o.path) return n.path < o.path;
      if (n.metric != o.metric) return n.metric > o.metric;
      if (xn != xo) return xn;
      if (n.age != o.age) return n.age < o.age;
      if (n.server != o.server) return n.server > o.server;
      return 0;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int hit;
      r.status = ST_READ_EMPTY;
      r.slot = 0;
      r.rt = '0;
      hit = -1;
      case (it.op)
        OP_CLEAR: begin
          total = 0;
          r.status = ST_CLEARED;
        end
        OP_OFFER: begin
          for (int i = 0; i < total; i++)
            if (hit < 0 && slots[i].family == it.rt.family && slots[i].prefix == it.rt.prefix)
              hit = i;
          if (hit >= 0) begin
            if (beats(it.rt, slots[hit])) begin
              slots[hit] = it.rt;
              r.status = ST_REPLACED;
            end else begin
              r.status = ST_KEPT;
            end
            r.slot = 8'(hit);
            r.rt = slots[hit];
          end else if (total < DEPTH) begin
            slots[total] = it.rt;
            r.slot = 8'(total);
            r.rt = it.rt;
            r.status = ST_INSERTED;
            total++;
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_READ: begin
          r.slot = it.rd_idx;
          if (it.rd_idx < total) begin
            r.status = ST_READ_VALID;
            r.rt = slots[it.rd_idx];
          end
        end
        default: ;
      endcase
      r.count = 9'(total);
      pending.push_back(r);
    endfunction

    task check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", got.status, 0);
        return;
      end
      e = pending.pop_front();
      if (got.status != e.status) report("status", got.status, e.status);
      if (got.slot != e.slot) report("slot_index", got.slot, e.slot);
      if (got.count != e.count) report("entry_count", got.count, e.count);
      if (got.rt.family != e.rt.family) report("family", got.rt.family, e.rt.family);
      if (got.rt.prefix != e.rt.prefix) report("prefix", got.rt.prefix, e.rt.prefix);
      if (got.rt.pref != e.rt.pref) report("pref", got.rt.pref, e.rt.pref);
      if (got.rt.rtype != e.rt.rtype) report("type", got.rt.rtype, e.rt.rtype);
      if (got.rt.path != e.rt.path) report("path_length", got.rt.path, e.rt.path);
      if (got.rt.metric != e.rt.metric) report("metric", got.rt.metric, e.rt.metric);
      if (got.rt.domain != e.rt.domain) report("domain", got.rt.domain, e.rt.domain);
      if (got.rt.server != e.rt.server) report("server_id", got.rt.server, e.rt.server);
      if (got.rt.age != e.rt.age) report("age", got.rt.age, e.rt.age);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [31:0] cfg_local_domain = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  route_t in_rt = '0;
  logic [7:0] in_read_index = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] out_status;
  logic [7:0] out_slot_index;
  logic [8:0] out_entry_count;
  route_t out_rt;

  best_route_selection_table_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_local_domain(cfg_local_domain),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_address_family(in_rt.family), .in_prefix_key(in_rt.prefix),
    .in_local_pref(in_rt.pref), .in_route_type(in_rt.rtype),
    .in_path_length(in_rt.path), .in_metric(in_rt.metric),
    .in_learn_domain(in_rt.domain), .in_learn_server_id(in_rt.server),
    .in_age_stamp(in_rt.age), .in_read_index(in_read_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_slot_index(out_slot_index), .out_entry_count(out_entry_count),
    .out_family(out_rt.family), .out_prefix(out_rt.prefix), .out_pref(out_rt.pref),
    .out_type(out_rt.rtype), .out_path_length(out_rt.path), .out_metric(out_rt.metric),
    .out_domain(out_rt.domain), .out_server_id(out_rt.server), .out_age(out_rt.age)
  );

  route_table_sb sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  longint cycles = 0;
  logic [31:0] dom_pool[4];
  logic [63:0] key_pool[8];

  initial begin
    forever #10 clk = ~clk;
  end

  // result side: sample at the edge, then pick the next stall value
  always @(posedge clk) begin
    result_t r;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      r.status = status_t'(out_status);
      r.slot = out_slot_index;
      r.count = out_entry_count;
      r.rt = out_rt;
      sb.check_result(r);
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic route_t rand_route(bit pooled);
    route_t r;
    r.family = pooled ? 16'($urandom_range(1)) : 16'($urandom);
    r.prefix = pooled ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
    r.pref = pooled ? $urandom_range(2) : $urandom;
    r.rtype = pooled ? 8'($urandom_range(1)) : 8'($urandom);
    r.path = pooled ? 8'($urandom_range(1)) : 8'($urandom);
    r.metric = pooled ? $urandom_range(1) : $urandom;
    r.domain = pooled ? dom_pool[$urandom_range(3)] : $urandom;
    r.server = pooled ? $urandom_range(1) : $urandom;
    r.age = pooled ? $urandom_range(1) : $urandom;
    return r;
  endfunction

  // valid stays high into the next item when there is no idle cycle
  task automatic send(op_t op, route_t rt, logic [7:0] idx);
    item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_rt <= rt;
    in_read_index <= idx;
    it.op = op;
    it.rt = rt;
    it.rd_idx = idx;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_domain(logic [31:0] d);
    cfg_valid <= 1;
    cfg_local_domain <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_domain(d);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 2) send(OP_CLEAR, rand_route(0), 8'($urandom));
      else if (sel < 4) send(OP_NONE, rand_route(0), 8'($urandom));
      else if (sel < 16) send(OP_READ, rand_route(0),
                              ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8)));
      else send(OP_OFFER, rand_route(sel < 90), 8'($urandom));
    end
  endtask

  initial begin
    route_t r;
    logic [31:0] doms[4];
    sb.set_domain(0);
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every opcode, ties, full table, out-of-range read
    dom_pool = '{32'd0, 32'd5, 32'hffff_ffff, 32'd7};
    send(OP_READ, '0, 8'd0);
    r = '0;
    send(OP_OFFER, r, 8'd0);
    send(OP_OFFER, r, 8'd0);              // exact tie keeps
    r.domain = 32'd9;
    send(OP_OFFER, r, 8'd0);              // external beats local
    r = '1;
    send(OP_OFFER, r, 8'd0);
    r.age = 32'hffff_fffe;
    send(OP_OFFER, r, 8'd0);              // older wins
    r.path = 8'h00;
    send(OP_OFFER, r, 8'd0);              // shorter path wins
    r.pref = 32'h0;
    send(OP_OFFER, r, 8'd0);              // lower pref kept
    send(OP_READ, '0, 8'd1);
    send(OP_READ, '0, 8'd2);
    send(OP_READ, '0, 8'hff);
    send(OP_NONE, '1, 8'hff);
    send(OP_CLEAR, '1, 8'hff);
    send(OP_READ, '0, 8'd0);
    drain();
    write_domain(32'hffff_ffff);
    for (int i = 0; i < DEPTH + 2; i++) begin
      r = rand_route(0);
      send(OP_OFFER, r, 8'd0);            // fills table, last two are full
    end
    send(OP_READ, '0, 8'hff);
    send(OP_CLEAR, '0, 8'd0);

    doms = '{32'd5, 32'd0, 32'd7, 32'h1234_5678};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_domain(doms[ph]);
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 79 : 27) : 0;
      recv_stall_pct = (ph == 2) ? 79 : (ph == 3 ? 27 : 0);
      if (ph == 0) hold_off <= 2000;      // fill up behind a blocked output
      random_phase(350);
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(30);
    drain();
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
